[sv/xid_parameter_stream_parser_core_defines.svh]
// ----------------------------------------------------------------------------
// XID parameter parser assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef XID_PARAMETER_STREAM_PARSER_CORE_DEFINES_SVH
`define XID_PARAMETER_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define XIDPSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("xidpsp: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define XIDPSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("xidpsp: next-cycle check failed");

`endif

[sv/xidpsp_pkg.sv]
// ----------------------------------------------------------------------------
// XID parameter parser package
// Transaction types and byte role codes shared by the parser files.
// ----------------------------------------------------------------------------
package xidpsp_pkg;

    localparam logic [1:0] ROLE_HEADER  = 2'd0;
    localparam logic [1:0] ROLE_EXTLEN  = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       last_byte;
    } xidpsp_in_t;

    typedef struct packed {
        logic [1:0] byte_role;
        logic [4:0] param_type;
        logic [7:0] param_length;
        logic [7:0] payload_byte;
        logic       field_complete;
        logic       message_ok;
        logic       truncated;
    } xidpsp_out_t;

endpackage

[sv/xidpsp_parser.sv]
// ----------------------------------------------------------------------------
// XID parameter parser step
// Holds the field parse state and classifies one message byte per advance.
// ----------------------------------------------------------------------------
module xidpsp_parser
    import xidpsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  xidpsp_in_t  item,
    output xidpsp_out_t result
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_EXTLEN  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [4:0] type_reg, type_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] remain_reg, remain_next;
    logic [1:0] high_reg, high_next;

    logic [7:0] ext_len;
    logic [7:0] hdr_len;
    logic [7:0] remain_dec;
    logic       done;

    assign ext_len    = {high_reg, item.msg_byte[7:2]};
    assign hdr_len    = {6'd0, item.msg_byte[1:0]};
    assign remain_dec = (remain_reg != 8'd0) ? (remain_reg - 8'd1) : 8'd0;

    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        length_next = length_reg;
        remain_next = remain_reg;
        high_next   = high_reg;
        done        = 1'b0;
        result      = '0;

        unique case (phase_reg)
            PH_EXTLEN: begin
                result.byte_role    = ROLE_EXTLEN;
                result.param_length = ext_len;
                done                = (ext_len == 8'd0);
                length_next         = ext_len;
                remain_next         = ext_len;
                phase_next          = done ? PH_HEADER : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                result.byte_role    = ROLE_PAYLOAD;
                result.param_length = length_reg;
                result.payload_byte = item.msg_byte;
                remain_next         = remain_dec;
                done                = (remain_dec == 8'd0);
                if (done) begin
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                result.byte_role = ROLE_HEADER;
                type_next        = item.msg_byte[6:2];
                if (item.msg_byte[7]) begin
                    high_next   = item.msg_byte[1:0];
                    length_next = 8'd0;
                    remain_next = 8'd0;
                    phase_next  = PH_EXTLEN;
                end else begin
                    result.param_length = hdr_len;
                    done                = (hdr_len == 8'd0);
                    length_next         = hdr_len;
                    remain_next         = hdr_len;
                    phase_next          = done ? PH_HEADER : PH_PAYLOAD;
                end
            end
        endcase

        result.param_type     = type_next;
        result.field_complete = done;
        result.message_ok     = item.last_byte & done;
        result.truncated      = item.last_byte & ~done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            type_reg   <= '0;
            length_reg <= '0;
            remain_reg <= '0;
            high_reg   <= '0;
        end else if (advance) begin
            if (item.last_byte) begin
                // drop all field state: the next byte opens a new message
                phase_reg  <= PH_HEADER;
                type_reg   <= '0;
                length_reg <= '0;
                remain_reg <= '0;
                high_reg   <= '0;
            end else begin
                phase_reg  <= phase_next;
                type_reg   <= type_next;
                length_reg <= length_next;
                remain_reg <= remain_next;
                high_reg   <= high_next;
            end
        end
    end

endmodule

[sv/xid_parameter_stream_parser_core.sv]
// ----------------------------------------------------------------------------
// XID parameter stream parser core
// Splits an XID message into parameter fields and tags every byte.
// ----------------------------------------------------------------------------
// The core takes one message byte per cycle while the result side is not
// stalled and returns one result transaction per byte. The byte lands in
// an input register at the accepting edge, then one pass of the field
// parser (header decode, extended length merge or payload countdown)
// writes the result register when the byte advances. The parser state
// advances only when a byte moves from the input register to the result
// register, so backpressure on the result side simply holds both
// registers; the input side stays ready while the input register is empty
// or the result register is free or being drained. A result with last_byte
// set reports message_ok or truncated and returns the parser to the header
// phase.
// ----------------------------------------------------------------------------
module xid_parameter_stream_parser_core
    import xidpsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  xidpsp_in_t  s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output xidpsp_out_t m_data
);

    logic        in_valid_reg;
    xidpsp_in_t  in_data_reg;
    logic        out_valid_reg;
    xidpsp_out_t out_data_reg;

    xidpsp_out_t step_result;
    logic        advance;

    // Advance a byte through the parser when the result register is free
    // or is handing its transaction off in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    xidpsp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .result  (step_result)
    );

    // Input register: hold the byte until the parser consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Result register: load on advance, clear once taken with nothing behind.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[sv/xidpsp_checker.sv]
// ----------------------------------------------------------------------------
// XID parameter parser port checker
// Watches the result port of the core for protocol and encoding slips.
// ----------------------------------------------------------------------------
`include "xid_parameter_stream_parser_core_defines.svh"

module xidpsp_checker
    import xidpsp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input xidpsp_out_t m_data
);

    // A stalled result transaction must hold.
    `XIDPSP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                        m_valid && $stable(m_data))

    // Good and truncated end marks never appear together.
    `XIDPSP_ASSERT_IMPLY(a_end_excl, aclk, aresetn, m_valid,
                         !(m_data.message_ok && m_data.truncated))

    // Only payload bytes carry data.
    `XIDPSP_ASSERT_IMPLY(a_pay_zero, aclk, aresetn,
                         m_valid && (m_data.byte_role != ROLE_PAYLOAD),
                         m_data.payload_byte == 8'd0)

    // A good end mark is always a completed field.
    `XIDPSP_ASSERT_IMPLY(a_ok_done, aclk, aresetn, m_valid && m_data.message_ok,
                         m_data.field_complete)

endmodule

bind xid_parameter_stream_parser_core xidpsp_checker u_xidpsp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// XID parameter stream parser testbench
// Drives XID messages byte by byte into the parser core and checks every
// result transaction against a cycle-free model of the field parser. Runs a
// short directed set, maximum-length fields, and random messages (mostly
// well formed, some cut short, some noise) under varying source and sink
// idling.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xidpsp_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 270;

    // Parse phases of the field decoder.
    typedef enum logic [1:0] {
        EXPECT_HEADER  = 2'd0,
        EXPECT_EXTLEN  = 2'd1,
        EXPECT_PAYLOAD = 2'd2
    } parse_phase_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    xidpsp_in_t  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    xidpsp_out_t m_data;

    // Source and sink idle rates, in percent of cycles.
    int src_idle_pct = 0;
    int dst_idle_pct = 0;

    int error_count = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    // Results predicted for accepted bytes, oldest first.
    xidpsp_out_t pending_results[$];

    // Model state of the field decoder.
    parse_phase_t rx_phase      = EXPECT_HEADER;
    logic [4:0]   field_type    = '0;
    logic [7:0]   field_len     = '0;
    logic [7:0]   payload_left  = '0;
    logic [1:0]   len_high_bits = '0;

    xid_parameter_stream_parser_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Open a field of the given length; a zero-length field closes at once.
    function automatic logic open_field(input logic [7:0] len);
        field_len    = len;
        payload_left = len;
        if (len == 8'd0) begin
            rx_phase = EXPECT_HEADER;
            return 1'b1;
        end
        rx_phase = EXPECT_PAYLOAD;
        return 1'b0;
    endfunction

    // Advance the model by one message byte and return the result it yields.
    function automatic xidpsp_out_t parse_xid_byte(input xidpsp_in_t item);
        xidpsp_out_t res;
        logic [7:0]  len;
        logic        done;
        res  = '0;
        done = 1'b0;
        case (rx_phase)
            EXPECT_EXTLEN: begin
                // Merge the two kept header bits with bits 7..2; drop bits 1..0.
                len = {len_high_bits, item.msg_byte[7:2]};
                res.byte_role    = ROLE_EXTLEN;
                res.param_length = len;
                done = open_field(len);
            end
            EXPECT_PAYLOAD: begin
                res.byte_role    = ROLE_PAYLOAD;
                res.payload_byte = item.msg_byte;
                res.param_length = field_len;
                if (payload_left != 8'd0) begin
                    payload_left = payload_left - 8'd1;
                end
                if (payload_left == 8'd0) begin
                    done     = 1'b1;
                    rx_phase = EXPECT_HEADER;
                end
            end
            default: begin
                res.byte_role = ROLE_HEADER;
                field_type    = item.msg_byte[6:2];
                if (item.msg_byte[7]) begin
                    // Extended form: length unknown until the next byte.
                    len_high_bits = item.msg_byte[1:0];
                    field_len     = 8'd0;
                    payload_left  = 8'd0;
                    rx_phase      = EXPECT_EXTLEN;
                end else begin
                    len = {6'd0, item.msg_byte[1:0]};
                    res.param_length = len;
                    done = open_field(len);
                end
            end
        endcase
        res.param_type     = field_type;
        res.field_complete = done;
        res.message_ok     = item.last_byte & done;
        res.truncated      = item.last_byte & ~done;
        // The final byte of a message returns the decoder to its reset state.
        if (item.last_byte) begin
            rx_phase      = EXPECT_HEADER;
            field_type    = '0;
            field_len     = '0;
            payload_left  = '0;
            len_high_bits = '0;
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Offer one byte, hold it until accepted, then record its expected result.
    // Called at a rising edge; leaves valid high so back-to-back bytes stream.
    task automatic push_xid_byte(input logic [7:0] b, input logic lst);
        xidpsp_in_t item;
        item.msg_byte  = b;
        item.last_byte = lst;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(parse_xid_byte(item));
        items_sent++;
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_for_results;
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Sink: throttle ready according to the current idle rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge aclk) begin
        xidpsp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing expected: %h", m_data));
            end else begin
                want = pending_results.pop_front();
                if (m_data.byte_role !== want.byte_role)
                    flag_mismatch($sformatf("byte_role got %0d expected %0d",
                                            m_data.byte_role, want.byte_role));
                if (m_data.param_type !== want.param_type)
                    flag_mismatch($sformatf("param_type got %0d expected %0d",
                                            m_data.param_type, want.param_type));
                if (m_data.param_length !== want.param_length)
                    flag_mismatch($sformatf("param_length got %0d expected %0d",
                                            m_data.param_length, want.param_length));
                if (m_data.payload_byte !== want.payload_byte)
                    flag_mismatch($sformatf("payload_byte got %h expected %h",
                                            m_data.payload_byte, want.payload_byte));
                if (m_data.field_complete !== want.field_complete)
                    flag_mismatch($sformatf("field_complete got %b expected %b",
                                            m_data.field_complete, want.field_complete));
                if (m_data.message_ok !== want.message_ok)
                    flag_mismatch($sformatf("message_ok got %b expected %b",
                                            m_data.message_ok, want.message_ok));
                if (m_data.truncated !== want.truncated)
                    flag_mismatch($sformatf("truncated got %b expected %b",
                                            m_data.truncated, want.truncated));
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Hand-picked bytes: extreme types and lengths, both header forms,
    // zero-length fields and truncation on each kind of byte.
    task automatic test_directed;
        // Short header, type 0, length 0: closes at once.
        push_xid_byte(8'h00, 1'b0);
        // Type 31, length 3, then payload extremes; ends exactly.
        push_xid_byte(8'h7F, 1'b0);
        push_xid_byte(8'h00, 1'b0);
        push_xid_byte(8'hFF, 1'b0);
        push_xid_byte(8'h5A, 1'b1);
        // Message cut on a header that still wants one payload byte.
        push_xid_byte(8'h05, 1'b1);
        // Extended header with a zero length; low bits of the length byte set.
        push_xid_byte(8'h80, 1'b0);
        push_xid_byte(8'h03, 1'b0);
        // Extended type 31, length 2, ends exactly.
        push_xid_byte(8'hFC, 1'b0);
        push_xid_byte(8'h0B, 1'b0);
        push_xid_byte(8'hFF, 1'b0);
        push_xid_byte(8'h00, 1'b1);
        // Cut on the extended length byte.
        push_xid_byte(8'h84, 1'b0);
        push_xid_byte(8'h40, 1'b1);
        // Cut inside the payload.
        push_xid_byte(8'h02, 1'b0);
        push_xid_byte(8'h11, 1'b1);
        // One-byte message that is an extended header.
        push_xid_byte(8'hFF, 1'b1);
        // Zero-length field as the final byte.
        push_xid_byte(8'h7C, 1'b1);
        // Extended header with high bits set, length 192, cut on the length byte.
        push_xid_byte(8'h83, 1'b0);
        push_xid_byte(8'h00, 1'b1);
    endtask

    // Two fields at the maximum length of 255, one per message.
    task automatic test_max_length;
        int i;
        for (int m = 0; m < 2; m++) begin
            push_xid_byte(8'h83 | (8'($urandom_range(31)) << 2), 1'b0);
            push_xid_byte(m == 0 ? 8'hFC : 8'hFF, 1'b0);
            for (i = 0; i < 255; i++) begin
                push_xid_byte(8'($urandom), i == 254);
            end
        end
    endtask

    // Send one random message: well formed, cut short, or plain noise.
    task automatic send_random_message;
        logic [7:0] msg[$];
        logic [7:0] len;
        logic [4:0] ptype;
        int         n_fields;
        int         kind;
        int         cut;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // Noise: random bytes, any may close a message; the last one always does.
            n_fields = $urandom_range(1, 8);
            for (int i = 0; i < n_fields; i++) begin
                push_xid_byte(8'($urandom), (i == n_fields - 1) || ($urandom_range(3) == 0));
            end
            return;
        end
        n_fields = $urandom_range(1, 4);
        for (int f = 0; f < n_fields; f++) begin
            ptype = 5'($urandom);
            if ($urandom_range(1)) begin
                len = 8'($urandom_range(3));
                msg.push_back({1'b0, ptype, len[1:0]});
            end else begin
                len = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(15));
                msg.push_back({1'b1, ptype, len[7:6]});
                msg.push_back({len[5:0], 2'($urandom)});
            end
            for (int i = 0; i < len; i++) msg.push_back(8'($urandom));
        end
        // Cut short: mark a random byte, at most the final one, as the last one.
        cut = msg.size();
        if (kind < 25) cut = $urandom_range(1, msg.size());
        for (int i = 0; i < cut; i++) begin
            push_xid_byte(msg[i], i == cut - 1);
        end
    endtask

    // Random traffic in three idle settings; pause once for a full drain.
    task automatic test_random_messages;
        int   phase_target;
        logic drained;
        drained      = 1'b0;
        phase_target = items_sent;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin src_idle_pct = 37; dst_idle_pct = 56; end
                1: begin src_idle_pct = 56; dst_idle_pct = 37; end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            phase_target = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < phase_target) begin
                send_random_message();
                // Hold the source until the sink has caught up, once in the first phase.
                if (p == 0 && !drained && items_sent >= phase_target - RANDOM_ITEMS / 6) begin
                    wait_for_results();
                    drained = 1'b1;
                end
            end
        end
    endtask

    initial begin
        src_idle_pct = 37;
        dst_idle_pct = 56;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_max_length();
        test_random_messages();

        // Drain everything outstanding, then let the pipeline settle.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
